/* rtl/core/tlpq_pkg.sv */
package tlpq_pkg;

    // Queue sizing.
    localparam int QUEUE_DEPTH = 256;
    localparam int ID_W        = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 2;
    localparam int ADDR_W      = PTR_W + 2;

    // Fixed field widths of the channels.
    localparam int TASK_W   = 16;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CLASS_W  = 2;
    localparam int TOTAL_W  = 10;

    // Operation codes carried by the mode field.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // Priority codes as requested on a push.
    typedef enum logic [PRIO_W-1:0] {
        PRIO_LOW    = 2'd0,
        PRIO_NORMAL = 2'd1,
        PRIO_HIGH   = 2'd2,
        PRIO_ALT    = 2'd3
    } t_prio;

    // Queue classes; the code is also the queue index.
    typedef enum logic [CLASS_W-1:0] {
        CLS_LOW    = 2'd0,
        CLS_NORMAL = 2'd1,
        CLS_HIGH   = 2'd2
    } t_class;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Access to the shared queue memory.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   wdata;
    } t_mem_req;

    // Everything about a word except the identifier read from memory.
    typedef struct packed {
        t_status              status;
        t_class               cls;
        logic                 popped;
        logic [TOTAL_W-1:0]   total;
    } t_item_info;

endpackage

/* rtl/core/tlpq_if.sv */
// Request channel: push or pop operations.
interface tlpq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [tlpq_pkg::TASK_W-1:0]       task_id;
    logic [tlpq_pkg::PRIO_W-1:0]       priority_req;

    modport source (output valid, mode, task_id, priority_req, input ready);
    modport sink   (input valid, mode, task_id, priority_req, output ready);
endinterface

// Result channel: one word for every request.
interface tlpq_out_if;
    logic                              valid;
    logic                              ready;
    logic [tlpq_pkg::STATUS_W-1:0]     status;
    logic [tlpq_pkg::TASK_W-1:0]       popped_id;
    logic [tlpq_pkg::CLASS_W-1:0]      popped_class;
    logic [tlpq_pkg::TOTAL_W-1:0]      total_count;

    modport source (output valid, status, popped_id, popped_class, total_count, input ready);
    modport sink   (input valid, status, popped_id, popped_class, total_count, output ready);
endinterface

/* rtl/core/tlpq_ram.sv */
// Simple dual-port memory: one write port, one registered read port.
module tlpq_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/tlpq_ctrl.sv */
// Queue bookkeeping: head and tail pointers and fill counts of the three
// classes, class selection, and the memory access for each operation.
module tlpq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_mode,
    input  logic [tlpq_pkg::TASK_W-1:0]   i_task_id,
    input  logic [tlpq_pkg::PRIO_W-1:0]   i_priority_req,
    output tlpq_pkg::t_mem_req            o_mem_req,
    output tlpq_pkg::t_item_info          o_info
);

    logic [tlpq_pkg::PTR_W-1:0] r_head [0:2];
    logic [tlpq_pkg::PTR_W-1:0] r_tail [0:2];
    logic [tlpq_pkg::CNT_W-1:0] r_cnt  [0:2];
    logic [tlpq_pkg::PTR_W-1:0] n_head [0:2];
    logic [tlpq_pkg::PTR_W-1:0] n_tail [0:2];
    logic [tlpq_pkg::CNT_W-1:0] n_cnt  [0:2];

    tlpq_pkg::t_class            push_cls;
    tlpq_pkg::t_class            pop_cls;
    logic                        pop_found;
    logic                        push_full;
    logic [tlpq_pkg::PTR_W-1:0]  push_ptr;
    logic [tlpq_pkg::PTR_W-1:0]  pop_ptr;
    logic [tlpq_pkg::SUM_W-1:0]  sum;

    // Map the requested priority onto a queue.
    always_comb begin
        unique case (tlpq_pkg::t_prio'(i_priority_req))
            tlpq_pkg::PRIO_HIGH: push_cls = tlpq_pkg::CLS_HIGH;
            tlpq_pkg::PRIO_LOW:  push_cls = tlpq_pkg::CLS_LOW;
            default:             push_cls = tlpq_pkg::CLS_NORMAL;
        endcase
    end

    // Highest non-empty queue for a pop.
    always_comb begin
        pop_found = 1'b1;
        if (r_cnt[tlpq_pkg::CLS_HIGH] != '0) begin
            pop_cls = tlpq_pkg::CLS_HIGH;
        end else if (r_cnt[tlpq_pkg::CLS_NORMAL] != '0) begin
            pop_cls = tlpq_pkg::CLS_NORMAL;
        end else if (r_cnt[tlpq_pkg::CLS_LOW] != '0) begin
            pop_cls = tlpq_pkg::CLS_LOW;
        end else begin
            pop_cls   = tlpq_pkg::CLS_LOW;
            pop_found = 1'b0;
        end
    end

    assign push_ptr  = r_tail[push_cls];
    assign pop_ptr   = r_head[pop_cls];
    assign push_full = (r_cnt[push_cls] >= tlpq_pkg::CNT_W'(tlpq_pkg::QUEUE_DEPTH));

    // Next pointers and counts.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_head[c] = r_head[c];
            n_tail[c] = r_tail[c];
            n_cnt[c]  = r_cnt[c];
        end
        if (i_fire) begin
            if (tlpq_pkg::t_op'(i_mode) == tlpq_pkg::OP_PUSH) begin
                if (!push_full) begin
                    n_tail[push_cls] =
                        (push_ptr == tlpq_pkg::PTR_W'(tlpq_pkg::QUEUE_DEPTH - 1))
                        ? '0 : push_ptr + 1'b1;
                    n_cnt[push_cls] = r_cnt[push_cls] + 1'b1;
                end
            end else if (pop_found) begin
                n_head[pop_cls] =
                    (pop_ptr == tlpq_pkg::PTR_W'(tlpq_pkg::QUEUE_DEPTH - 1))
                    ? '0 : pop_ptr + 1'b1;
                n_cnt[pop_cls] = r_cnt[pop_cls] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            for (int c = 0; c < 3; c++) begin
                r_head[c] <= n_head[c];
                r_tail[c] <= n_tail[c];
                r_cnt[c]  <= n_cnt[c];
            end
        end
    end

    // Total held after the operation.
    assign sum = tlpq_pkg::SUM_W'(n_cnt[0]) + tlpq_pkg::SUM_W'(n_cnt[1])
               + tlpq_pkg::SUM_W'(n_cnt[2]);

    // Memory access: write the tail on a push, read the head on a pop.
    always_comb begin
        o_mem_req.we    = 1'b0;
        o_mem_req.re    = 1'b0;
        o_mem_req.wdata = tlpq_pkg::ID_W'(i_task_id);
        o_mem_req.addr  = {push_cls, push_ptr};
        o_info.status   = tlpq_pkg::ST_OK;
        o_info.cls      = tlpq_pkg::CLS_LOW;
        o_info.popped   = 1'b0;
        o_info.total    = tlpq_pkg::TOTAL_W'(sum);
        if (tlpq_pkg::t_op'(i_mode) == tlpq_pkg::OP_PUSH) begin
            o_mem_req.we = i_fire && !push_full;
            if (push_full) begin
                o_info.status = tlpq_pkg::ST_FULL;
            end
        end else begin
            o_mem_req.addr = {pop_cls, pop_ptr};
            o_mem_req.re   = i_fire && pop_found;
            if (pop_found) begin
                o_info.cls    = pop_cls;
                o_info.popped = 1'b1;
            end else begin
                o_info.status = tlpq_pkg::ST_EMPTY;
            end
        end
    end

endmodule

/* rtl/core/three_level_priority_task_queue.sv */
// Channel   Direction  Fields
// i_in      in         mode, task_id, priority_req
// o_out     out        status, popped_id, popped_class, total_count
//
// Sustains one request per cycle while the output is not stalled. A result word
// is offered from the output register: the queue memory read and the read stage
// register when the request is accepted, and the output register loads from the
// read stage when it advances. Reset clears all pointers and counts; the queue
// memory itself is not cleared and needs no clearing pass. A stalled output
// holds the request channel once the read stage is also occupied.
module three_level_priority_task_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlpq_in_if.sink    i_in,
    tlpq_out_if.source o_out
);

    tlpq_pkg::t_mem_req            mem_req;
    tlpq_pkg::t_item_info          info;
    logic [tlpq_pkg::ID_W-1:0]     rd_data;
    logic                          fire;
    logic                          advance;

    logic                          r_p_valid;
    tlpq_pkg::t_item_info          r_p_info;
    logic                          r_o_valid;
    logic [tlpq_pkg::STATUS_W-1:0] r_o_status;
    logic [tlpq_pkg::TASK_W-1:0]   r_o_id;
    logic [tlpq_pkg::CLASS_W-1:0]  r_o_class;
    logic [tlpq_pkg::TOTAL_W-1:0]  r_o_total;

    // Handshake between the read stage and the output register.
    assign advance    = r_p_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_p_valid || advance;
    assign fire       = i_in.valid && i_in.ready;

    tlpq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_mode         (i_in.mode),
        .i_task_id      (i_in.task_id),
        .i_priority_req (i_in.priority_req),
        .o_mem_req      (mem_req),
        .o_info         (info)
    );

    tlpq_ram #(
        .DATA_W (tlpq_pkg::ID_W),
        .ADDR_W (tlpq_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.addr),
        .o_rdata (rd_data)
    );

    // Read stage: waits for the memory data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (fire) begin
            r_p_valid <= 1'b1;
        end else if (advance) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_p_info <= info;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_status <= r_p_info.status;
            r_o_class  <= r_p_info.cls;
            r_o_total  <= r_p_info.total;
            r_o_id     <= r_p_info.popped ? tlpq_pkg::TASK_W'(rd_data) : '0;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.popped_id    = r_o_id;
    assign o_out.popped_class = r_o_class;
    assign o_out.total_count  = r_o_total;

endmodule
